// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the checker module m4cm_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define M4_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define M4_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/m4cm_pkg.sv -----
// ---------------------------------------------------------------------------
// m4cm_pkg
// Types, constants and arithmetic helpers of the 4x4 matrix chain multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

package m4cm_pkg;

    // Geometry and widths
    localparam int DIM        = 4;
    localparam int ELEM_W     = 32;
    localparam int ACC_W      = 48;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int IDX_W      = $clog2(DIM);
    localparam int KIND_W     = 2;
    localparam int IN_DATA_W  = DIM * ELEM_W;
    localparam int OUT_FLD_W  = DIM * ELEM_W + IDX_W + 1;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int PAD_W      = OUT_DATA_W - OUT_FLD_W;

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_RES    = DIM;

    localparam logic signed [ELEM_W-1:0] ONE_Q16 = 32'sh0001_0000;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_FIRST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VEC   = 2'd2;

    // Per-step control that travels down the lane pipeline
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  step;
        logic [IDX_W-1:0]  row;
        logic              first;
        logic              closing;
    } t_ctl;

    // Element saturated to 32 bits plus its overflow flag
    typedef struct packed {
        logic                     ovf;
        logic signed [ELEM_W-1:0] val;
    } t_sat;

    // One result item
    typedef struct packed {
        logic [DIM-1:0][ELEM_W-1:0] res;
        logic [IDX_W-1:0]           row;
        logic                       is_vector;
        logic                       last;
        logic                       ovf;
    } t_res_item;

    // 48-bit add that saturates at -2^47 and 2^47-1
    function automatic logic signed [ACC_W-1:0] f_add_sat48(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    // Saturate an accumulator value to 32 bits signed
    function automatic t_sat f_sat32(input logic signed [ACC_W-1:0] v);
        t_sat r;
        if ((&v[ACC_W-1:ELEM_W-1]) || !(|v[ACC_W-1:ELEM_W-1])) begin
            r.ovf = 1'b0;
            r.val = v[ELEM_W-1:0];
        end else begin
            r.ovf = 1'b1;
            r.val = v[ACC_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/m4cm_lane.sv -----
// ---------------------------------------------------------------------------
// m4cm_lane
// One column lane: holds column j of the product and of the accumulator,
// runs one registered 32x32 multiply per cycle and the row update.
// ---------------------------------------------------------------------------
`default_nettype none

module m4cm_lane
    import m4cm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [IDX_W-1:0]         i_lane,     // column this lane owns
    input  wire logic [IDX_W-1:0]         i_rd_step,  // product row to read
    output logic signed [ELEM_W-1:0]      o_p_rd,
    input  wire logic signed [ELEM_W-1:0] i_a,
    input  wire logic signed [ELEM_W-1:0] i_b,
    input  wire t_ctl                     i_c1,       // control aligned with product
    input  wire t_ctl                     i_c2,       // control aligned with new acc
    output logic signed [ACC_W-1:0]       o_t,
    output t_sat                          o_res
);

    logic signed [ELEM_W-1:0] r_p_col [DIM];
    logic signed [ACC_W-1:0]  r_acc [DIM];
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_new;
    t_sat                     r_res;

    logic signed [ACC_W-1:0]  w_base;
    logic signed [ACC_W-1:0]  n_acc;
    t_sat                     w_sat;

    assign o_p_rd = r_p_col[i_rd_step];

    // Exact Q32.32 product, truncated toward minus infinity by dropping 16 bits
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end
    assign o_t = r_prod[PROD_W-1:PROD_W-ACC_W];

    // Row update; the first row of a matrix treats the accumulator as zero
    always_comb begin
        w_base = i_c1.first ? '0 : r_acc[i_c1.step];
        if (i_c1.kind == KIND_FIRST) begin
            n_acc = (i_c1.step == i_c1.row) ? o_t : w_base;
        end else begin
            n_acc = f_add_sat48(w_base, o_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_c1.valid && (i_c1.kind != KIND_VEC)) begin
            r_acc[i_c1.step] <= n_acc;
            r_new            <= n_acc;
        end
    end

    // Closing row: saturate, load the product and hand the element on
    assign w_sat = f_sat32(r_new);

    always_ff @(posedge i_clk) begin
        if (i_c2.valid && i_c2.closing) begin
            r_res <= w_sat;
        end
    end
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIM; i++) begin
                r_p_col[i] <= (IDX_W'(i) == i_lane) ? ONE_Q16 : '0;
            end
        end else if (i_c2.valid && i_c2.closing) begin
            r_p_col[i_c2.step] <= w_sat.val;
        end
    end

endmodule

`default_nettype wire

// ----- design/m4cm_merge.sv -----
// ---------------------------------------------------------------------------
// m4cm_merge
// Combines lane outputs: saturating sum of the lane terms for vectors,
// row assembly and overflow merge for product rows.
// ---------------------------------------------------------------------------
`default_nettype none

module m4cm_merge
    import m4cm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_ctl                     i_c1,
    input  wire logic signed [ACC_W-1:0]  i_t [DIM],
    input  wire t_ctl                     i_c3,
    input  wire t_sat                     i_res [DIM],
    output logic                          o_push,
    output t_res_item                     o_item
);

    // Vector reduction pipeline, terms added in lane order
    logic                     r_v2_vld, r_v3_vld, r_v4_vld;
    logic [IDX_W-1:0]         r_v2_step, r_v3_step, r_v4_step;
    logic signed [ACC_W-1:0]  r_s01, r_t2, r_t3a;
    logic signed [ACC_W-1:0]  r_s012, r_t3b;
    logic signed [ACC_W-1:0]  r_sf;
    logic [ELEM_W-1:0]        r_vec [DIM-1];
    logic                     r_vovf;

    // Matrix row delay stage
    logic                     r_m_vld;
    logic [IDX_W-1:0]         r_m_step;
    logic [DIM-1:0][ELEM_W-1:0] r_m_res;
    logic                     r_m_ovf;

    t_sat                     w_el;
    logic                     w_vpush;
    logic                     w_any_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2_vld <= 1'b0;
            r_v3_vld <= 1'b0;
            r_v4_vld <= 1'b0;
            r_m_vld  <= 1'b0;
        end else begin
            r_v2_vld <= i_c1.valid && (i_c1.kind == KIND_VEC);
            r_v3_vld <= r_v2_vld;
            r_v4_vld <= r_v3_vld;
            r_m_vld  <= i_c3.valid && i_c3.closing;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v2_step <= i_c1.step;
        r_s01     <= f_add_sat48(i_t[0], i_t[1]);
        r_t2      <= i_t[2];
        r_t3a     <= i_t[3];
        r_v3_step <= r_v2_step;
        r_s012    <= f_add_sat48(r_s01, r_t2);
        r_t3b     <= r_t3a;
        r_v4_step <= r_v3_step;
        r_sf      <= f_add_sat48(r_s012, r_t3b);
    end

    // Collect vector elements; the last one goes out straight from the sum
    assign w_el    = f_sat32(r_sf);
    assign w_vpush = r_v4_vld && (r_v4_step == IDX_W'(DIM - 1));

    always_ff @(posedge i_clk) begin
        if (r_v4_vld && !w_vpush) begin
            r_vec[r_v4_step] <= w_el.val;
            r_vovf <= (r_v4_step == '0) ? w_el.ovf : (r_vovf | w_el.ovf);
        end
    end

    // Product row: merge the lane overflow flags
    always_comb begin
        w_any_ovf = 1'b0;
        for (int j = 0; j < DIM; j++) begin
            w_any_ovf = w_any_ovf | i_res[j].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_step <= i_c3.step;
        r_m_ovf  <= w_any_ovf;
        for (int j = 0; j < DIM; j++) begin
            r_m_res[j] <= i_res[j].val;
        end
    end

    // Result item; vector and row pushes never coincide
    assign o_push = w_vpush | r_m_vld;

    always_comb begin
        if (w_vpush) begin
            for (int j = 0; j < DIM - 1; j++) begin
                o_item.res[j] = r_vec[j];
            end
            o_item.res[DIM-1] = w_el.val;
            o_item.row        = '0;
            o_item.is_vector  = 1'b1;
            o_item.last       = 1'b1;
            o_item.ovf        = r_vovf | w_el.ovf;
        end else begin
            o_item.res        = r_m_res;
            o_item.row        = r_m_step;
            o_item.is_vector  = 1'b0;
            o_item.last       = (r_m_step == IDX_W'(DIM - 1));
            o_item.ovf        = r_m_ovf;
        end
    end

endmodule

`default_nettype wire

// ----- design/m4cm_out_fifo.sv -----
// ---------------------------------------------------------------------------
// m4cm_out_fifo
// Result queue with slot reservation, so that the lane pipeline never
// has to stall once an item is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module m4cm_out_fifo
    import m4cm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire t_res_item        i_item,
    input  wire logic             i_take,   // input transaction this cycle
    input  wire logic [CNT_W-1:0] i_need,   // slots that transaction reserves
    output logic                  o_room,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_res_item             o_item
);

    t_res_item          r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_credit;
    logic               w_pop;

    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rd];
    assign o_room  = (r_credit >= CNT_W'(MAX_RES));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Pointers, fill count and unreserved slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_cnt    <= '0;
            r_credit <= CNT_W'(FIFO_DEPTH);
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt    <= r_cnt + CNT_W'(i_push) - CNT_W'(w_pop);
            r_credit <= r_credit - (i_take ? i_need : '0) + CNT_W'(w_pop);
        end
    end

endmodule

`default_nettype wire

// ----- design/matrix4_chain_multiplier_unit.sv -----
// ---------------------------------------------------------------------------
// matrix4_chain_multiplier_unit
// Running 4x4 Q16.16 matrix product with vector transform, four lanes.
// ---------------------------------------------------------------------------
// Throughput: given queue room, the next input transaction is taken in the last step of the current one,
//   and each of the four column lanes runs one multiply per cycle over the rows.
// Results: a vector result passes the product and reduction adder registers, and the
//   rows of a finished matrix follow its last row; an 8-deep queue holds off input
//   while fewer than 4 unreserved slots remain.
// Reset (synchronous, active low): product identity, row count zero, queue empty.
`default_nettype none

module matrix4_chain_multiplier_unit
    import m4cm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // elem0, elem1, elem2, elem3
    input  wire logic [KIND_W-1:0]     i_s_axis_tuser,   // kind
    // Result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,   // res0..res3, res_row, overflow
    output logic [0:0]                 o_m_axis_tuser,   // is_vector
    output logic                       o_m_axis_tlast    // last
);

    // Sequencer state
    logic                     r_busy;
    logic [IDX_W-1:0]         r_step;
    logic [IDX_W-1:0]         r_row_cnt;

    // Current item
    logic [KIND_W-1:0]        r_kind;
    logic signed [ELEM_W-1:0] r_elem [DIM];
    logic [IDX_W-1:0]         r_row;
    logic                     r_first;
    logic                     r_closing;

    // Control pipeline
    t_ctl                     w_c0, r_c1, r_c2, r_c3;

    logic                     w_take, w_start, w_is_row, w_room;
    logic [CNT_W-1:0]         w_need;

    logic signed [ELEM_W-1:0] w_p_rd [DIM];
    logic signed [ELEM_W-1:0] w_a [DIM];
    logic signed [ACC_W-1:0]  w_t [DIM];
    t_sat                     w_res [DIM];

    logic                     w_push;
    t_res_item                w_push_item, w_out_item;

    // Input transaction and slot demand
    assign w_take   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_row = (i_s_axis_tuser == KIND_FIRST) || (i_s_axis_tuser == KIND_NEXT);
    assign w_start  = w_take && (w_is_row || (i_s_axis_tuser == KIND_VEC));
    assign o_s_axis_tready = (!r_busy || (r_step == IDX_W'(DIM - 1))) && w_room;

    always_comb begin
        if (i_s_axis_tuser == KIND_VEC) begin
            w_need = CNT_W'(1);
        end else if (w_is_row && (r_row_cnt == IDX_W'(DIM - 1))) begin
            w_need = CNT_W'(DIM);
        end else begin
            w_need = '0;
        end
    end

    // Step sequencer and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_step    <= '0;
            r_row_cnt <= '0;
        end else begin
            if (w_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == IDX_W'(DIM - 1)) begin
                    r_busy <= 1'b0;
                    r_step <= '0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            if (w_take && w_is_row) begin
                r_row_cnt <= (r_row_cnt == IDX_W'(DIM - 1)) ? '0 : r_row_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_kind    <= i_s_axis_tuser;
            r_row     <= r_row_cnt;
            r_first   <= (r_row_cnt == '0);
            r_closing <= w_is_row && (r_row_cnt == IDX_W'(DIM - 1));
            for (int j = 0; j < DIM; j++) begin
                r_elem[j] <= i_s_axis_tdata[j*ELEM_W +: ELEM_W];
            end
        end
    end

    // Control travels alongside the lane data
    assign w_c0 = '{valid: r_busy, kind: r_kind, step: r_step, row: r_row,
                    first: r_first, closing: r_closing};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
        end else begin
            r_c1 <= w_c0;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
        end
    end

    // Multiplier operand: identity for a loaded row, own column for a
    // vector, product column of the row number for a chained matrix
    always_comb begin
        for (int j = 0; j < DIM; j++) begin
            if (r_kind == KIND_FIRST) begin
                w_a[j] = ONE_Q16;
            end else if (r_kind == KIND_VEC) begin
                w_a[j] = w_p_rd[j];
            end else begin
                w_a[j] = w_p_rd[r_row];
            end
        end
    end

    // Column lanes
    for (genvar j = 0; j < DIM; j++) begin : g_lane
        m4cm_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_lane    (IDX_W'(j)),
            .i_rd_step (r_step),
            .o_p_rd    (w_p_rd[j]),
            .i_a       (w_a[j]),
            .i_b       (r_elem[j]),
            .i_c1      (r_c1),
            .i_c2      (r_c2),
            .o_t       (w_t[j]),
            .o_res     (w_res[j])
        );
    end

    m4cm_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_c1    (r_c1),
        .i_t     (w_t),
        .i_c3    (r_c3),
        .i_res   (w_res),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    m4cm_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_take  (w_take),
        .i_need  (w_need),
        .o_room  (w_room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_item  (w_out_item)
    );

    // Result stream packing
    assign o_m_axis_tdata = {{PAD_W{1'b0}}, w_out_item.ovf, w_out_item.row, w_out_item.res};
    assign o_m_axis_tuser = w_out_item.is_vector;
    assign o_m_axis_tlast = w_out_item.last;

endmodule

`default_nettype wire

// ----- design/m4cm_checker.sv -----
// ---------------------------------------------------------------------------
// m4cm_checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module m4cm_checker
    import m4cm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,
    input  wire logic [0:0]            i_m_tuser,
    input  wire logic                  i_m_tlast
);

    logic [IDX_W-1:0] w_row;
    assign w_row = i_m_tdata[DIM*ELEM_W +: IDX_W];

    // A vector transaction is a single, last result of row zero
    `M4_ASSERT_IMP(a_vec_last, i_clk, i_rst_n, i_m_tvalid && i_m_tuser[0], i_m_tlast, "vector result without tlast")
    `M4_ASSERT_IMP(a_vec_row, i_clk, i_rst_n, i_m_tvalid && i_m_tuser[0], w_row == '0, "vector result with nonzero row")

    // Product rows: tlast exactly on the final row
    `M4_ASSERT_IMP(a_row_last, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser[0], i_m_tlast == (w_row == IDX_W'(DIM - 1)), "tlast does not match final product row")

    // Stalled result holds
    `M4_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast), "stalled result changed")

endmodule

bind matrix4_chain_multiplier_unit m4cm_checker u_m4cm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser),
    .i_m_tlast  (o_m_axis_tlast)
);

`default_nettype wire

// ----- tb/sv/m4cm_stream_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// m4cm_stream_checker
// Watches both streams of the matrix chain multiplier, keeps its own running
// product and accumulator, and compares every result transaction in order.
// ---------------------------------------------------------------------------

module m4cm_stream_checker
    import m4cm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream, as seen at the block
    input  wire logic                  i_in_tvalid,
    input  wire logic                  i_in_tready,
    input  wire logic [IN_DATA_W-1:0]  i_in_tdata,    // elem0, elem1, elem2, elem3
    input  wire logic [KIND_W-1:0]     i_in_tuser,    // kind
    // Result stream, as seen at the block
    input  wire logic                  i_out_tvalid,
    input  wire logic                  i_out_tready,
    input  wire logic [OUT_DATA_W-1:0] i_out_tdata,   // res0..res3, res_row, overflow
    input  wire logic [0:0]            i_out_tuser,   // is_vector
    input  wire logic                  i_out_tlast,   // last
    // Status for the stimulus side
    output int                         o_error_count,
    output int                         o_results_due
);

    localparam longint ACC_TOP  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_BOT  = -ACC_TOP - 1;
    localparam longint ELEM_TOP = 64'sh0000_0000_7FFF_FFFF;
    localparam longint ELEM_BOT = -ELEM_TOP - 1;
    localparam int     ROW_LSB  = DIM * ELEM_W;
    localparam int     OVF_BIT  = ROW_LSB + IDX_W;

    // Running product, accumulator and row position of the current matrix
    logic signed [ELEM_W-1:0] prod_q [DIM*DIM];
    longint                   acc_q  [DIM*DIM];
    int                       rows_seen;

    // Results predicted but not yet seen, oldest first
    t_res_item due_results [$];

    // Q16.16 x Q16.16, exact then truncated toward minus infinity
    function automatic longint q16_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    // 48-bit accumulate with saturation
    function automatic longint acc_add(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > ACC_TOP) return ACC_TOP;
        if (s < ACC_BOT) return ACC_BOT;
        return s;
    endfunction

    // Accumulator value down to one 32-bit element
    function automatic t_sat clamp_elem(input longint v);
        t_sat r;
        r.ovf = 1'b1;
        if (v > ELEM_TOP) r.val = 32'sh7FFF_FFFF;
        else if (v < ELEM_BOT) r.val = 32'sh8000_0000;
        else begin
            r.ovf = 1'b0;
            r.val = v[ELEM_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        o_error_count++;
    endtask

    task automatic reset_chain();
        for (int k = 0; k < DIM * DIM; k++) begin
            prod_q[k] = (k / DIM == k % DIM) ? ONE_Q16 : '0;
            acc_q[k]  = 0;
        end
        rows_seen = 0;
        due_results.delete();
    endtask

    // Work out what one input transaction produces
    task automatic predict_transform(input logic [KIND_W-1:0] kind,
                                     input logic [IN_DATA_W-1:0] data);
        longint    elem [DIM];
        longint    sum;
        t_sat      el;
        t_res_item r;
        for (int j = 0; j < DIM; j++)
            elem[j] = signed'(data[j*ELEM_W +: ELEM_W]);
        case (kind)
            KIND_VEC: begin
                // P * v, leaves the chain alone
                r = '0;
                r.is_vector = 1'b1;
                r.last = 1'b1;
                for (int i = 0; i < DIM; i++) begin
                    sum = 0;
                    for (int j = 0; j < DIM; j++)
                        sum = acc_add(sum, q16_mul(prod_q[i*DIM + j], elem[j]));
                    el = clamp_elem(sum);
                    r.res[i] = el.val;
                    r.ovf |= el.ovf;
                end
                due_results.push_back(r);
            end
            KIND_FIRST, KIND_NEXT: begin
                // first row of any matrix starts from a clean accumulator
                if (rows_seen == 0)
                    for (int k = 0; k < DIM * DIM; k++) acc_q[k] = 0;
                if (kind == KIND_FIRST) begin
                    for (int j = 0; j < DIM; j++) acc_q[rows_seen*DIM + j] = elem[j];
                end else begin
                    for (int i = 0; i < DIM; i++)
                        for (int j = 0; j < DIM; j++)
                            acc_q[i*DIM + j] = acc_add(acc_q[i*DIM + j],
                                q16_mul(prod_q[i*DIM + rows_seen], elem[j]));
                end
                if (rows_seen + 1 < DIM) begin
                    rows_seen++;
                end else begin
                    // matrix complete: commit and emit its rows
                    rows_seen = 0;
                    for (int i = 0; i < DIM; i++) begin
                        r = '0;
                        r.row  = IDX_W'(i);
                        r.last = (i == DIM - 1);
                        for (int j = 0; j < DIM; j++) begin
                            el = clamp_elem(acc_q[i*DIM + j]);
                            r.res[j] = el.val;
                            r.ovf |= el.ovf;
                            prod_q[i*DIM + j] = el.val;
                        end
                        due_results.push_back(r);
                    end
                end
            end
            default: ;  // unused kind, ignored
        endcase
    endtask

    task automatic check_result();
        t_res_item want;
        if (due_results.size() == 0) begin
            report_mismatch("result with nothing due", i_out_tdata[63:0], '0);
            return;
        end
        want = due_results.pop_front();
        for (int j = 0; j < DIM; j++)
            if (i_out_tdata[j*ELEM_W +: ELEM_W] !== want.res[j])
                report_mismatch($sformatf("res%0d", j),
                                i_out_tdata[j*ELEM_W +: ELEM_W], want.res[j]);
        if (i_out_tdata[ROW_LSB +: IDX_W] !== want.row)
            report_mismatch("res_row", i_out_tdata[ROW_LSB +: IDX_W], want.row);
        if (i_out_tdata[OVF_BIT] !== want.ovf)
            report_mismatch("overflow", i_out_tdata[OVF_BIT], want.ovf);
        if (i_out_tuser[0] !== want.is_vector)
            report_mismatch("is_vector", i_out_tuser[0], want.is_vector);
        if (i_out_tlast !== want.last)
            report_mismatch("last", i_out_tlast, want.last);
    endtask

    // A result never leaves at the clock edge at which its input is taken, so the
    // result side is handled first at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_chain();
        end else begin
            if (i_out_tvalid && i_out_tready) check_result();
            if (i_in_tvalid && i_in_tready) predict_transform(i_in_tuser, i_in_tdata);
        end
        o_results_due = due_results.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Stream stimulus for the matrix chain multiplier: directed extremes, then
// random matrices and vectors under changing idle and stall patterns, with
// one long result hold-off and drain pauses. Checking lives in the checker.
// ---------------------------------------------------------------------------

module testbench;
    import m4cm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [ELEM_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] Q_MIN     = 32'h8000_0000;
    localparam logic [ELEM_W-1:0] Q_ONE     = ONE_Q16;
    localparam logic [ELEM_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    int error_count;
    int results_due;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;

    matrix4_chain_multiplier_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    m4cm_stream_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_tvalid   (s_tvalid),
        .i_in_tready   (s_tready),
        .i_in_tdata    (s_tdata),
        .i_in_tuser    (s_tuser),
        .i_out_tvalid  (m_tvalid),
        .i_out_tready  (m_tready),
        .i_out_tdata   (m_tdata),
        .i_out_tuser   (m_tuser),
        .i_out_tlast   (m_tlast),
        .o_error_count (error_count),
        .o_results_due (results_due)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side: random stalls, or a long hold-off when asked for
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: cycles without any transaction on either side
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] row4(input logic [ELEM_W-1:0] e0,
        input logic [ELEM_W-1:0] e1, input logic [ELEM_W-1:0] e2,
        input logic [ELEM_W-1:0] e3);
        return {e3, e2, e1, e0};
    endfunction

    // Mostly moderate values; tame ones, bar the rare extremes, stay within +-1.0 so chains last
    function automatic logic [ELEM_W-1:0] rand_elem(input bit tame);
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick == 0) return $urandom;
        if (pick == 1) begin
            case ($urandom_range(4))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return '0;
                3: return Q_ONE;
                default: return Q_NEG_ONE;
            endcase
        end
        if (tame) return $urandom_range(2 * ONE_Q16) - ONE_Q16;
        if (pick < 6) return $urandom;
        return $urandom_range(32 * ONE_Q16) - 16 * ONE_Q16;
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_row(input bit tame);
        return row4(rand_elem(tame), rand_elem(tame), rand_elem(tame), rand_elem(tame));
    endfunction

    // Present one transaction; entered and left at a falling edge
    task automatic offer(input logic [KIND_W-1:0] kind, input logic [IN_DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (results_due != 0) @(negedge clk);
    endtask

    // Matrices with random content, some of them partial, vectors, some noise
    task automatic random_traffic(input int n_items);
        int          sent;
        int          n_rows;
        int unsigned pick;
        bit          chain;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                offer(KIND_IGNORED, {$urandom, $urandom, $urandom, $urandom});
            end else if (pick < 24) begin
                offer(KIND_VEC, rand_row(1'b0));
                sent++;
            end else begin
                chain  = (pick >= 58);
                n_rows = (pick < 28) ? $urandom_range(1, DIM - 1) : DIM;
                for (int r = 0; r < n_rows; r++) begin
                    if ($urandom_range(9) == 0) begin
                        offer(KIND_VEC, rand_row(1'b0));
                        sent++;
                    end
                    if (pick >= 92)
                        offer($urandom_range(1) ? KIND_NEXT : KIND_FIRST, rand_row(1'b1));
                    else
                        offer(chain ? KIND_NEXT : KIND_FIRST, rand_row(chain));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = KIND_FIRST;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // vector through the identity, and an unused kind
        offer(KIND_VEC, row4(Q_ONE, Q_NEG_ONE, Q_MAX, Q_MIN));
        offer(KIND_IGNORED, '1);
        // first matrix built from the extremes
        offer(KIND_FIRST, row4(Q_MAX, Q_MIN, '0, Q_ONE));
        offer(KIND_FIRST, row4(Q_MIN, Q_MAX, Q_ONE, '0));
        offer(KIND_FIRST, row4('0, Q_ONE, Q_MAX, Q_MIN));
        offer(KIND_FIRST, row4(Q_ONE, '0, Q_MIN, Q_MAX));
        // saturating vector, then a saturating chained matrix
        offer(KIND_VEC, row4(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        offer(KIND_NEXT, row4(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        offer(KIND_NEXT, row4(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        offer(KIND_NEXT, row4(Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        offer(KIND_NEXT, row4(Q_MAX, Q_MAX, Q_MIN, Q_MIN));
        // mixed kinds with a vector in the middle of the matrix
        offer(KIND_FIRST, row4(Q_ONE, 32'h0002_0000, '0, '0));
        offer(KIND_NEXT, row4(Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        offer(KIND_VEC, row4(Q_ONE, '0, '0, '0));
        offer(KIND_FIRST, row4('0, '0, Q_ONE, '0));
        offer(KIND_NEXT, row4(Q_NEG_ONE, '0, '0, Q_ONE));
        // back to identity, then scale; a half times -1 LSB truncates downward
        for (int i = 0; i < DIM; i++)
            offer(KIND_FIRST, Q_ONE << (i * ELEM_W));
        offer(KIND_NEXT, row4(32'h0002_0000, '0, '0, '0));
        offer(KIND_NEXT, row4('0, 32'hFFFE_8000, '0, '0));
        offer(KIND_NEXT, row4('0, '0, 32'h0001_8000, 32'h0000_0001));
        offer(KIND_NEXT, row4('0, '0, '0, 32'h0000_8000));
        offer(KIND_VEC, row4(32'h0003_8000, 32'hFFFF_C000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        // no idling
        random_traffic(16);
        drain();
        // sender mostly idle
        send_idle_pct = 76;
        random_traffic(14);
        // long result hold-off while the sender keeps going
        send_idle_pct = 0;
        hold_req = 1'b1;
        random_traffic(12);
        // receiver mostly stalled
        recv_stall_pct = 76;
        random_traffic(14);
        drain();
        // both sides idle now and then
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        random_traffic(14);

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
